### hdl/wpsm_pkg.sv
// shared types and constants for the wav pcm stream to mono volume block
// no dependencies
package wpsm_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int HDR_LEN = 44;
    localparam int VOL_DIV = 21;
    localparam int RECIP_SHIFT = 25;
    localparam logic [20:0] RECIP_K = 21'((2**RECIP_SHIFT + VOL_DIV - 1) / VOL_DIV);
    localparam logic [4:0] VOL_MAX = 5'(VOL_DIV);
    localparam logic [4:0] VOL_RESET = 5'd10;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CHUNK = 3'd1;
    localparam logic [2:0] PH_SKIP = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_FINISHED = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    typedef struct packed {
        logic [1:0] kind;
        logic signed [15:0] smp;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] depth;
        logic fin;
    } work_t;

endpackage

### hdl/wpsm_front.sv
// parser front end: walks the riff header and chunks, one byte a cycle while accept is high
// depends on wpsm_pkg
module wpsm_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       file_byte,
    input  logic             file_end,
    output logic             word_valid,
    output wpsm_pkg::work_t  word
);

    logic [2:0]  phase_reg, phase_next;
    logic [5:0]  off_reg, off_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] size_reg, size_next;
    logic [2:0]  hbc_reg, hbc_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] data_reg, data_next;
    logic [15:0] ch_reg, ch_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] depth_reg, depth_next;
    logic [7:0]  held_reg, held_next;
    logic        pp_reg, pp_next;
    logic        par_reg, par_next;

    logic        first_v;
    logic        emit_smp;
    logic [15:0] smp;
    logic [31:0] tag_byte;
    logic [7:0]  exp_byte;

    always_comb begin
        phase_next = phase_reg;
        off_next = off_reg;
        tag_next = tag_reg;
        size_next = size_reg;
        hbc_next = hbc_reg;
        skip_next = skip_reg;
        data_next = data_reg;
        ch_next = ch_reg;
        rate_next = rate_reg;
        depth_next = depth_reg;
        held_next = held_reg;
        pp_next = pp_reg;
        par_next = par_reg;
        first_v = 1'b0;
        emit_smp = 1'b0;
        smp = '0;
        word = '0;
        tag_byte = (off_reg < 6'd4) ? wpsm_pkg::TAG_RIFF : wpsm_pkg::TAG_WAVE;
        exp_byte = tag_byte[8*(3 - off_reg[1:0]) +: 8];

        if (phase_reg <= wpsm_pkg::PH_SKIP) begin
            case (off_reg)
                6'd22: ch_next[7:0] = file_byte;
                6'd23: ch_next[15:8] = file_byte;
                6'd24: rate_next[7:0] = file_byte;
                6'd25: rate_next[15:8] = file_byte;
                6'd26: rate_next[23:16] = file_byte;
                6'd27: rate_next[31:24] = file_byte;
                6'd34: depth_next[7:0] = file_byte;
                6'd35: depth_next[15:8] = file_byte;
                default: ;
            endcase
        end

        case (phase_reg)
            wpsm_pkg::PH_HEADER: begin
                if ((off_reg < 6'd4 || (off_reg >= 6'd8 && off_reg < 6'd12)) &&
                    file_byte != exp_byte) begin
                    first_v = 1'b1;
                    word.kind = wpsm_pkg::KIND_INVALID;
                    phase_next = wpsm_pkg::PH_DONE;
                end else if (off_reg >= 6'd11) begin
                    phase_next = wpsm_pkg::PH_CHUNK;
                    hbc_next = '0;
                end
            end
            wpsm_pkg::PH_CHUNK: begin
                if (hbc_reg < 3'd4) begin
                    tag_next = (hbc_reg == 3'd0) ? {24'd0, file_byte}
                                                 : {tag_reg[23:0], file_byte};
                end else begin
                    size_next[8*hbc_reg[1:0] +: 8] = file_byte;
                end
                hbc_next = hbc_reg + 3'd1;
                if (hbc_reg == 3'd7) begin
                    if (tag_next == wpsm_pkg::TAG_DATA) begin
                        first_v = 1'b1;
                        if (off_reg < 6'(wpsm_pkg::HDR_LEN - 1)) begin
                            word.kind = wpsm_pkg::KIND_INVALID;
                            phase_next = wpsm_pkg::PH_DONE;
                        end else begin
                            word.kind = wpsm_pkg::KIND_FORMAT;
                            word.channels = ch_next;
                            word.rate = rate_next;
                            word.depth = depth_next;
                            data_next = size_next;
                            phase_next = wpsm_pkg::PH_DATA;
                            if (size_next == 32'd0 || file_end) begin
                                word.fin = 1'b1;
                                phase_next = wpsm_pkg::PH_DONE;
                            end
                        end
                    end else if (size_next != 32'd0) begin
                        skip_next = size_next;
                        phase_next = wpsm_pkg::PH_SKIP;
                    end
                end
            end
            wpsm_pkg::PH_SKIP: begin
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0) begin
                    phase_next = wpsm_pkg::PH_CHUNK;
                end
            end
            wpsm_pkg::PH_DATA: begin
                if (depth_reg == 16'd8) begin
                    emit_smp = 1'b1;
                    smp = {~file_byte[7], file_byte[6:0], 8'd0};
                end else if (!pp_reg) begin
                    held_next = file_byte;
                    pp_next = 1'b1;
                end else begin
                    emit_smp = 1'b1;
                    smp = {file_byte, held_reg};
                    pp_next = 1'b0;
                end
                if (emit_smp && ch_reg == 16'd2) begin
                    par_next = ~par_reg;
                    if (par_reg) begin
                        emit_smp = 1'b0;
                    end
                end
                data_next = data_reg - 32'd1;
                if (emit_smp) begin
                    first_v = 1'b1;
                    word.kind = wpsm_pkg::KIND_SAMPLE;
                    word.smp = smp;
                end
                if (data_next == 32'd0 || file_end) begin
                    phase_next = wpsm_pkg::PH_DONE;
                    if (emit_smp) begin
                        word.fin = 1'b1;
                    end else begin
                        first_v = 1'b1;
                        word.kind = wpsm_pkg::KIND_FINISHED;
                    end
                end
            end
            default: ;
        endcase

        if (file_end && phase_next <= wpsm_pkg::PH_SKIP) begin
            first_v = 1'b1;
            word.kind = wpsm_pkg::KIND_INVALID;
        end

        if (off_reg < 6'(wpsm_pkg::HDR_LEN)) begin
            off_next = off_reg + 6'd1;
        end
        if (file_end) begin
            phase_next = wpsm_pkg::PH_HEADER;
            off_next = '0;
            tag_next = '0;
            size_next = '0;
            hbc_next = '0;
            skip_next = '0;
            data_next = '0;
            held_next = '0;
            pp_next = 1'b0;
            par_next = 1'b0;
        end
        word_valid = first_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wpsm_pkg::PH_HEADER;
            off_reg <= '0;
            tag_reg <= '0;
            size_reg <= '0;
            hbc_reg <= '0;
            skip_reg <= '0;
            data_reg <= '0;
            ch_reg <= 16'd1;
            rate_reg <= 32'd16000;
            depth_reg <= 16'd16;
            held_reg <= '0;
            pp_reg <= 1'b0;
            par_reg <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            off_reg <= off_next;
            tag_reg <= tag_next;
            size_reg <= size_next;
            hbc_reg <= hbc_next;
            skip_reg <= skip_next;
            data_reg <= data_next;
            ch_reg <= ch_next;
            rate_reg <= rate_next;
            depth_reg <= depth_next;
            held_reg <= held_next;
            pp_reg <= pp_next;
            par_reg <= par_next;
        end
    end

endmodule

### hdl/wpsm_fifo.sv
// short register queue between parser front end and scaling back end
// depends on wpsm_pkg
module wpsm_fifo #(
    parameter int DEPTH = wpsm_pkg::FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  wpsm_pkg::work_t  push_word,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output wpsm_pkg::work_t  head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wpsm_pkg::work_t mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic do_push, do_pop;

    assign full = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

### hdl/wpsm_back.sv
// scaling back end: volume multiply, divide by 21 by reciprocal, result register
// depends on wpsm_pkg
module wpsm_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [4:0]       cfg_wdata,
    input  logic             in_valid,
    input  wpsm_pkg::work_t  in_word,
    output logic             in_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [79:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    logic [4:0] vol_reg;
    logic v1_reg, v2_reg, v3_reg, sent_reg;
    wpsm_pkg::work_t w1_reg, w2_reg, w3_reg;
    wpsm_pkg::work_t w3_next;
    logic signed [21:0] p1_reg;
    logic [41:0] q2_reg;
    logic neg2_reg;
    logic [20:0] mag;
    logic [16:0] q;
    logic [15:0] res;
    logic en;

    assign en = !v3_reg || (m_tready && (!w3_reg.fin || sent_reg));
    assign in_pop = en && in_valid;
    assign mag = p1_reg[21] ? 21'(-p1_reg) : 21'(p1_reg);
    assign q = q2_reg[wpsm_pkg::RECIP_SHIFT +: 17];
    assign res = neg2_reg ? 16'(-q) : q[15:0];

    always_comb begin
        w3_next = w2_reg;
        if (w2_reg.kind == wpsm_pkg::KIND_SAMPLE) begin
            w3_next.smp = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_reg <= wpsm_pkg::VOL_RESET;
        end else if (cfg_we) begin
            vol_reg <= (cfg_wdata > wpsm_pkg::VOL_MAX) ? wpsm_pkg::VOL_MAX : cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w1_reg <= in_word;
            p1_reg <= 22'(in_word.smp) * $signed({1'b0, vol_reg});
            w2_reg <= w1_reg;
            q2_reg <= 42'(mag) * 42'(wpsm_pkg::RECIP_K);
            neg2_reg <= p1_reg[21];
            w3_reg <= w3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            sent_reg <= 1'b0;
        end else begin
            if (en) begin
                v1_reg <= in_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                sent_reg <= 1'b0;
            end else if (v3_reg && m_tready) begin
                sent_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tuser = sent_reg ? wpsm_pkg::KIND_FINISHED : w3_reg.kind;
    assign m_tlast = !w3_reg.fin || sent_reg;
    assign m_tdata = sent_reg ? 80'd0
                   : {w3_reg.depth, w3_reg.rate, w3_reg.channels, w3_reg.smp};

endmodule

### hdl/wav_pcm_stream_to_mono_volume_core.sv
// top level of the wav pcm stream to mono volume block
// depends on wpsm_pkg, wpsm_front, wpsm_fifo, wpsm_back
//
// s_ channel: one byte of a wav file per word, s_tlast on the final byte of a file.
// m_ channel: result words; m_tuser kind (format, sample, finished, invalid),
// m_tdata sample / channels / rate / depth, m_tlast on the final result of a byte.
// cfg_we with cfg_wdata sets the volume (0..21, larger values clamp, reset 10).
// a byte is taken every cycle while s_tready is high; a byte yields zero, one or two results.
// the first result is written to the queue on the accepting edge, then passes the volume
// multiply, reciprocal multiply and result register, which raises m_tvalid.
// a byte yielding two results holds the back end until its second result is taken.
// when the receiver stalls the back end holds its word, the queue of
// FIFO_DEPTH words fills and then s_tready falls.
// reset empties the queue, clears the parser and restores the header
// defaults (1 channel, 16000 Hz, 16 bit) and volume 10.
module wav_pcm_stream_to_mono_volume_core #(
    parameter int FIFO_DEPTH = wpsm_pkg::FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // file_byte
    input  logic        s_tlast,     // file_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,     // sample, channels, rate, depth
    output logic [1:0]  m_tuser,     // kind
    output logic        m_tlast      // last
);

    logic accept, word_valid, full, not_empty, pop;
    wpsm_pkg::work_t word, head;

    assign s_tready = !full;
    assign accept = s_tvalid && s_tready;

    wpsm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .accept(accept),
        .file_byte(s_tdata), .file_end(s_tlast),
        .word_valid(word_valid), .word(word)
    );

    wpsm_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(accept && word_valid), .push_word(word), .full(full),
        .pop(pop), .not_empty(not_empty), .head(head)
    );

    wpsm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(not_empty), .in_word(head), .in_pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule

### hdl/wpsm_checker.sv
// port-level checks for the wav pcm stream to mono volume block, with bind
// depends on wpsm_pkg and wav_pcm_stream_to_mono_volume_core
module wpsm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_sample_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == wpsm_pkg::KIND_SAMPLE |-> m_tdata[79:16] == 64'd0)
        else $error("sample word carries header fields");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == wpsm_pkg::KIND_FINISHED ||
                     m_tuser == wpsm_pkg::KIND_INVALID) |-> m_tdata == 80'd0)
        else $error("status word carries data");

endmodule

bind wav_pcm_stream_to_mono_volume_core wpsm_checker u_wpsm_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
